>>> hw/rtl/assert_macros.svh
// Assertion macros for the checker, included by ppb_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: %m");

// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed: %m");

`endif

>>> hw/rtl/ppb_pkg.sv
// Types and constants of the projected point bounding box.
`timescale 1ns / 1ps
`default_nettype none

package ppb_pkg;

   // Width of the projection sums and of the divider.
   localparam int DIV_BITS = 52;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

   // Low-res to high-res remap.
   localparam int LR_WIDTH = 512;
   localparam int LR_HEIGHT = 424;
   localparam int LR_TOP = 19;
   localparam int LR_BOTTOM = 35;
   localparam int HR_WIDTH = 1920;
   localparam int HR_LEFT = 255;
   localparam int HR_RIGHT = 157;
   localparam int HR_HEIGHT = 1080;
   localparam int HR_ACTUAL_W = HR_WIDTH - HR_LEFT - HR_RIGHT;
   localparam int LR_ACTUAL_H = LR_HEIGHT - LR_TOP - LR_BOTTOM;

   localparam logic [23:0] LIMITS_RESET = 24'd4425600;

   // Register indexes.
   localparam logic [2:0] REG_ROW0_LOW  = 3'd0;
   localparam logic [2:0] REG_ROW0_HIGH = 3'd1;
   localparam logic [2:0] REG_ROW1_LOW  = 3'd2;
   localparam logic [2:0] REG_ROW1_HIGH = 3'd3;
   localparam logic [2:0] REG_ROW2_LOW  = 3'd4;
   localparam logic [2:0] REG_ROW2_HIGH = 3'd5;
   localparam logic [2:0] REG_HIRES     = 3'd6;
   localparam logic [2:0] REG_LIMITS    = 3'd7;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MUL   = 9'b000000010,
      ST_DRAIN = 9'b000000100,
      ST_CHECK = 9'b000001000,
      ST_DIV   = 9'b000010000,
      ST_RMUL  = 9'b000100000,
      ST_RDIV  = 9'b001000000,
      ST_TRACK = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_row;
      logic [1:0] mul_term;
      logic       div_start;
      logic       remap_mul;
      logic       take_proj;
      logic       take_remap;
      logic       track;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic w_zero;
      logic div_done;
      logic hires;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/ppb_div.sv
// Two-lane restoring divider, signed, truncating toward zero, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module ppb_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [ppb_pkg::DIV_BITS-1:0]  num_a,
   input  wire logic signed [ppb_pkg::DIV_BITS-1:0]  den_a,
   input  wire logic signed [ppb_pkg::DIV_BITS-1:0]  num_b,
   input  wire logic signed [ppb_pkg::DIV_BITS-1:0]  den_b,
   output logic signed [ppb_pkg::DIV_BITS-1:0]       quo_a,
   output logic signed [ppb_pkg::DIV_BITS-1:0]       quo_b,
   output logic                                      done
);

   localparam int DB = ppb_pkg::DIV_BITS;
   localparam int CB = ppb_pkg::DIV_CNT_BITS;

   logic [DB-1:0] rem_ff [2];
   logic [DB-1:0] rem_in [2];
   logic [DB-1:0] quo_ff [2];
   logic [DB-1:0] quo_in [2];
   logic [DB-1:0] dvs_ff [2];
   logic [1:0]    neg_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [CB-1:0] cnt_ff;
   logic [DB:0]   shifted [2];

   function automatic logic [DB-1:0] mag(input logic signed [DB-1:0] v);
      mag = v[DB-1] ? DB'(-v) : DB'(v);
   endfunction

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         shifted[i] = {rem_ff[i], quo_ff[i][DB-1]};
         if (shifted[i] >= {1'b0, dvs_ff[i]}) begin
            rem_in[i] = DB'(shifted[i] - {1'b0, dvs_ff[i]});
            quo_in[i] = {quo_ff[i][DB-2:0], 1'b1};
         end else begin
            rem_in[i] = shifted[i][DB-1:0];
            quo_in[i] = {quo_ff[i][DB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff[0] <= '0;
         rem_ff[1] <= '0;
         quo_ff[0] <= mag(num_a);
         quo_ff[1] <= mag(num_b);
         dvs_ff[0] <= mag(den_a);
         dvs_ff[1] <= mag(den_b);
         neg_ff    <= {num_b[DB-1] ^ den_b[DB-1], num_a[DB-1] ^ den_a[DB-1]};
      end else if (busy_ff) begin
         for (int i = 0; i < 2; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CB'(DB - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quo_a = neg_ff[0] ? -$signed(quo_ff[0]) : $signed(quo_ff[0]);
   assign quo_b = neg_ff[1] ? -$signed(quo_ff[1]) : $signed(quo_ff[1]);
   assign done  = done_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ppb_dp.sv
// Datapath: registers, projection multiplier, divider, remap, tracker, result.
`timescale 1ns / 1ps
`default_nettype none

module ppb_dp #(
   parameter int COORD_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_addr,
   input  wire logic [63:0]        csr_wdata,
   input  wire logic [95:0]        req_tdata,
   input  wire ppb_pkg::cmd_type   cmd,
   output ppb_pkg::status_type     status,
   output logic [63:0]             rsp_tdata,
   output logic                    rsp_tuser
);

   localparam int DB = ppb_pkg::DIV_BITS;
   localparam int C  = COORD_BITS;
   localparam int RW = COORD_BITS + 12;
   localparam int EW = COORD_BITS + 2;
   localparam int OW = (EW > 17) ? EW : 17;
   localparam logic signed [DB-1:0] CMAX = DB'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [DB-1:0] CMIN = -CMAX - DB'(1);
   // remap: /512 by shift, /370 by reciprocal multiply (exact for |n| < 2^(RW-1))
   localparam int RSH = $clog2(ppb_pkg::LR_WIDTH);
   localparam int RK  = RW - 1 + $clog2(ppb_pkg::LR_ACTUAL_H);
   localparam longint RCP_L = ((64'sd1 <<< RK) + longint'(ppb_pkg::LR_ACTUAL_H) - 64'sd1)
                              / longint'(ppb_pkg::LR_ACTUAL_H);
   localparam logic [RW-1:0] RCP = RW'(RCP_L);

   // configuration
   logic [63:0] coef_ff [6];
   logic        hires_ff;
   logic [23:0] limits_ff;

   // point and projection sums
   logic signed [31:0]   pt_ff [3];
   logic signed [63:0]   prod_ff;
   logic [1:0]           prod_row_ff;
   logic                 prod_vld_ff;
   logic signed [DB-1:0] acc_ff [3];

   logic [63:0]        coef_word;
   logic signed [31:0] coef_sel;
   logic signed [31:0] coord_sel;

   // divider
   logic signed [DB-1:0] quo_a, quo_b;
   logic                 div_done;

   // remap
   logic signed [RW-1:0] rm_a_ff, rm_b_ff;
   logic signed [RW-1:0] rq_a;
   logic [RW-1:0]        rm_b_mag;
   logic [2*RW-1:0]      rcp_prod;
   logic signed [DB-1:0] rq_b;

   // tracked coordinates and box
   logic signed [C-1:0] col_ff, row_ff;
   logic signed [C-1:0] min_col_ff, max_col_ff, min_row_ff, max_row_ff;
   logic                skip_ff;

   // result
   logic [14:0] rx_ff, ry_ff;
   logic [15:0] rw_ff, rh_ff;
   logic        rz_ff;

   function automatic logic signed [C-1:0] sat_c(input logic signed [DB-1:0] v);
      if (v > CMAX) sat_c = C'(CMAX);
      else if (v < CMIN) sat_c = C'(CMIN);
      else sat_c = C'(v);
   endfunction

   function automatic logic [15:0] sat16(input logic signed [OW-1:0] v);
      if (v > OW'(32767)) sat16 = 16'h7fff;
      else if (v < -OW'(32768)) sat16 = 16'h8000;
      else sat16 = v[15:0];
   endfunction

   function automatic logic [14:0] sat15(input logic signed [OW-1:0] v);
      if (v > OW'(32767)) sat15 = 15'h7fff;
      else sat15 = v[14:0];
   endfunction

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) coef_ff[i] <= '0;
         hires_ff  <= 1'b0;
         limits_ff <= ppb_pkg::LIMITS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            ppb_pkg::REG_ROW0_LOW:  coef_ff[0] <= csr_wdata;
            ppb_pkg::REG_ROW0_HIGH: coef_ff[1] <= csr_wdata;
            ppb_pkg::REG_ROW1_LOW:  coef_ff[2] <= csr_wdata;
            ppb_pkg::REG_ROW1_HIGH: coef_ff[3] <= csr_wdata;
            ppb_pkg::REG_ROW2_LOW:  coef_ff[4] <= csr_wdata;
            ppb_pkg::REG_ROW2_HIGH: coef_ff[5] <= csr_wdata;
            ppb_pkg::REG_HIRES:     hires_ff   <= csr_wdata[0];
            ppb_pkg::REG_LIMITS:    limits_ff  <= csr_wdata[23:0];
         endcase
      end
   end

   // coefficient k of a row sits in word row*2 + k/2, half k%2
   always_comb begin
      coef_word = coef_ff[{cmd.mul_row, cmd.mul_term[1]} < 3'd6 ?
                          3'({cmd.mul_row, cmd.mul_term[1]}) : 3'd0];
      coef_sel  = cmd.mul_term[0] ? coef_word[63:32] : coef_word[31:0];
      coord_sel = (cmd.mul_term == 2'd0) ? pt_ff[0] :
                  (cmd.mul_term == 2'd1) ? pt_ff[1] : pt_ff[2];
   end

   // multiply, then floor to Q16.16 and accumulate in the next cycle
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pt_ff[0] <= req_tdata[31:0];
         pt_ff[1] <= req_tdata[63:32];
         pt_ff[2] <= req_tdata[95:64];
      end
      prod_ff     <= coef_sel * coord_sel;
      prod_row_ff <= cmd.mul_row;
   end

   always_ff @(posedge clock) begin
      if (reset) prod_vld_ff <= 1'b0;
      else prod_vld_ff <= cmd.mul_en;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         // start each sum from the row's constant term
         acc_ff[0] <= DB'($signed(coef_ff[1][63:32]));
         acc_ff[1] <= DB'($signed(coef_ff[3][63:32]));
         acc_ff[2] <= DB'($signed(coef_ff[5][63:32]));
      end else if (prod_vld_ff) begin
         for (int r = 0; r < 3; r++) begin
            if (prod_row_ff == 2'(r)) acc_ff[r] <= acc_ff[r] + DB'(prod_ff >>> 16);
         end
      end
   end

   ppb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num_a (acc_ff[0]),
      .den_a (acc_ff[2]),
      .num_b (acc_ff[1]),
      .den_b (acc_ff[2]),
      .quo_a (quo_a),
      .quo_b (quo_b),
      .done  (div_done)
   );

   // remap numerators, registered ahead of the scaling
   always_ff @(posedge clock) begin
      if (cmd.remap_mul) begin
         rm_a_ff <= RW'(col_ff) * RW'(ppb_pkg::HR_ACTUAL_W);
         rm_b_ff <= (RW'(row_ff) - RW'(ppb_pkg::LR_TOP)) * RW'(ppb_pkg::HR_HEIGHT);
      end
   end

   // truncating scale: shift with bias for negatives, reciprocal on magnitude
   always_comb begin
      rq_a     = rm_a_ff[RW-1] ? (rm_a_ff + RW'(ppb_pkg::LR_WIDTH - 1)) >>> RSH
                               : rm_a_ff >>> RSH;
      rm_b_mag = rm_b_ff[RW-1] ? RW'(-rm_b_ff) : RW'(rm_b_ff);
      rcp_prod = (2*RW)'(rm_b_mag) * (2*RW)'(RCP);
      rq_b     = DB'(rcp_prod >> RK);
      if (rm_b_ff[RW-1]) rq_b = -rq_b;
   end

   always_ff @(posedge clock) begin
      if (cmd.take_proj) begin
         col_ff <= sat_c(quo_a);
         row_ff <= sat_c(quo_b);
      end else if (cmd.take_remap) begin
         col_ff <= sat_c(DB'(rq_a) + DB'(ppb_pkg::HR_LEFT));
         row_ff <= sat_c(rq_b);
      end
   end

   // box tracker and result
   logic signed [EW-1:0] cols_e, rows_e, x0, x1, y0, y1;
   logic signed [EW-1:0] dx, dy;

   always_comb begin
      cols_e = $signed({{(EW - 12){1'b0}}, limits_ff[11:0]});
      rows_e = $signed({{(EW - 12){1'b0}}, limits_ff[23:12]});
      x0 = (min_col_ff < 0) ? '0 : EW'(min_col_ff);
      y0 = (min_row_ff < 0) ? '0 : EW'(min_row_ff);
      x1 = (EW'(max_col_ff) >= cols_e) ? cols_e - EW'(1) : EW'(max_col_ff);
      y1 = (EW'(max_row_ff) >= rows_e) ? rows_e - EW'(1) : EW'(max_row_ff);
      dx = x1 - x0;
      dy = y1 - y0;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         min_col_ff <= C'(CMAX);
         min_row_ff <= C'(CMAX);
         max_col_ff <= '1;
         max_row_ff <= '1;
         skip_ff    <= 1'b0;
      end else if (cmd.track) begin
         if (status.w_zero) begin
            skip_ff <= 1'b1;
         end else begin
            if (col_ff > max_col_ff) max_col_ff <= col_ff;
            if (col_ff < min_col_ff) min_col_ff <= col_ff;
            if (row_ff > max_row_ff) max_row_ff <= row_ff;
            if (row_ff < min_row_ff) min_row_ff <= row_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rx_ff <= sat15(OW'(x0));
         ry_ff <= sat15(OW'(y0));
         rw_ff <= sat16(OW'(dx));
         rh_ff <= sat16(OW'(dy));
         rz_ff <= skip_ff;
      end
   end

   assign status.w_zero   = (acc_ff[2] == '0);
   assign status.div_done = div_done;
   assign status.hires    = hires_ff;

   assign rsp_tdata = {2'b00, rh_ff, rw_ff, ry_ff, rx_ff};
   assign rsp_tuser = rz_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ppb_ctrl.sv
// Controller: sequences the multiply, divide, remap and tracking of each point, and emits the box at a cloud's end.
`timescale 1ns / 1ps
`default_nettype none

module ppb_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic                 req_tlast,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire ppb_pkg::status_type  status,
   output ppb_pkg::cmd_type          cmd
);

   ppb_pkg::state_type state_ff, state_in;
   logic [1:0] row_ff, row_in, term_ff, term_in;
   logic       last_ff;
   logic       vld_ff;
   logic       out_free;

   assign out_free = !vld_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      term_in  = term_ff;
      cmd      = '0;
      cmd.mul_row  = row_ff;
      cmd.mul_term = term_ff;
      unique case (state_ff)
         ppb_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               row_in   = 2'd0;
               term_in  = 2'd0;
               state_in = ppb_pkg::ST_MUL;
            end
         end
         ppb_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
            if (term_ff == 2'd2) begin
               term_in = 2'd0;
               row_in  = row_ff + 2'd1;
               if (row_ff == 2'd2) state_in = ppb_pkg::ST_DRAIN;
            end else begin
               term_in = term_ff + 2'd1;
            end
         end
         ppb_pkg::ST_DRAIN: state_in = ppb_pkg::ST_CHECK;
         ppb_pkg::ST_CHECK: begin
            if (status.w_zero) begin
               state_in = ppb_pkg::ST_TRACK;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ppb_pkg::ST_DIV;
            end
         end
         ppb_pkg::ST_DIV: begin
            if (status.div_done) begin
               cmd.take_proj = 1'b1;
               state_in = status.hires ? ppb_pkg::ST_RMUL : ppb_pkg::ST_TRACK;
            end
         end
         ppb_pkg::ST_RMUL: begin
            cmd.remap_mul = 1'b1;
            state_in      = ppb_pkg::ST_RDIV;
         end
         ppb_pkg::ST_RDIV: begin
            cmd.take_remap = 1'b1;
            state_in       = ppb_pkg::ST_TRACK;
         end
         ppb_pkg::ST_TRACK: begin
            cmd.track = 1'b1;
            state_in  = last_ff ? ppb_pkg::ST_EMIT : ppb_pkg::ST_IDLE;
         end
         ppb_pkg::ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ppb_pkg::ST_IDLE;
            end
         end
         default: state_in = ppb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppb_pkg::ST_IDLE;
         row_ff   <= '0;
         term_ff  <= '0;
         last_ff  <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         term_ff  <= term_in;
         if (cmd.load) last_ff <= req_tlast;
         if (cmd.emit) vld_ff <= 1'b1;
         else if (rsp_tready) vld_ff <= 1'b0;
      end
   end

   assign req_tready = (state_ff == ppb_pkg::ST_IDLE);
   assign rsp_tvalid = vld_ff;

endmodule

`default_nettype wire

>>> hw/rtl/projected_point_bounding_box.sv
// Top level of the projected point bounding box.
//
// Request channel req_*: one 3D point per request (x, y, z in signed Q16.16),
// req_tlast marks the last point of a cloud. Result channel rsp_*: one box per
// cloud, sent after the last point has been processed.
// csr_*: write-only registers (projection matrix, hi-res mode, image limits),
// written by the user only while the block is idle; the block does not enforce it.
// Each point is projected through one shared 32x32 multiplier and divided by a
// two-lane restoring divider (one quotient bit per cycle); a new request is
// taken only once the last point has been tracked. Hi-res mode adds a remap
// (constant multiply, then shift and reciprocal multiply). A point of zero
// depth skips the divider. After a cloud's last point is tracked, its box is
// latched into the output register in the emit state, which waits while the
// previous box is still held; the next request can be taken in the cycle that
// box goes out.
// Reset clears the registers to their defaults and empties the tracker.
// The result sits in an output register; while rsp_tready is low the block
// keeps taking points and only waits when the next box is ready to go out.
`timescale 1ns / 1ps
`default_nettype none

module projected_point_bounding_box #(
   parameter int COORD_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [63:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,    // point_x, point_y, point_z
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,    // rect_x, rect_y, rect_width, rect_height
   output logic             rsp_tuser     // zero_depth_seen
);

   ppb_pkg::cmd_type    cmd;
   ppb_pkg::status_type status;

   ppb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ppb_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

>>> hw/rtl/ppb_checker.sv
// Port checker for the projected point bounding box, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ppb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   `ASSERT_AT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `ASSERT_AT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable({rsp_tuser, rsp_tdata}))
   `ASSERT_AT(a_one_request, clock, reset, req_tvalid && req_tready |=> !req_tready)
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid && req_tready)

endmodule

bind projected_point_bounding_box ppb_checker u_ppb_checker (.*);

`default_nettype wire
